[hdl/fqnt_pkg.sv]
// Shared types, codes and helper functions for the float32 affine quantiser.
// No dependencies; imported by every module of the block.
package fqnt_pkg;

  localparam logic [2:0] TYPE_INT8   = 3'd0;
  localparam logic [2:0] TYPE_UINT8  = 3'd1;
  localparam logic [2:0] TYPE_INT16  = 3'd2;
  localparam logic [2:0] TYPE_UINT16 = 3'd3;
  localparam logic [2:0] TYPE_INT32  = 3'd4;
  localparam logic [2:0] TYPE_UINT32 = 3'd5;

  localparam logic [1:0] REG_SCALE = 2'd0;
  localparam logic [1:0] REG_ZERO  = 2'd1;
  localparam logic [1:0] REG_TYPE  = 2'd2;

  localparam logic [31:0] SCALE_RESET = 32'h3F80_0000;

  localparam int DIV_STEPS           = 26;
  localparam int DIV_STEPS_PER_STAGE = 2;
  localparam int DIV_STAGES          = DIV_STEPS / DIV_STEPS_PER_STAGE;

  typedef struct packed {
    logic last;
    logic bad;
  } fq_tag_t;

  // unpacked finite float: expo is the effective field (1 for subnormal/zero)
  typedef struct packed {
    logic        sign;
    logic [7:0]  expo;
    logic [23:0] mant;
  } fq_num_t;

  typedef struct packed {
    logic        sign;
    logic        nan;
    logic        inf;
    logic [8:0]  expo;
    logic [23:0] mant;
  } fq_sum_t;

  function automatic logic [5:0] lzc32(input logic [31:0] x);
    logic [5:0] n;
    logic       found;
    n     = 6'd32;
    found = 1'b0;
    for (int i = 31; i >= 0; i--) begin
      if (!found && x[i]) begin
        n     = 6'(31 - i);
        found = 1'b1;
      end
    end
    return n;
  endfunction

  function automatic logic signed [33:0] type_lo(input logic [2:0] t);
    logic signed [33:0] v;
    case (t)
      TYPE_INT8:  v = -34'sd128;
      TYPE_INT16: v = -34'sd32768;
      TYPE_INT32: v = -34'sd2147483648;
      default:    v = 34'sd0;
    endcase
    return v;
  endfunction

  function automatic logic signed [33:0] type_hi(input logic [2:0] t);
    logic signed [33:0] v;
    case (t)
      TYPE_INT8:   v = 34'sd127;
      TYPE_UINT8:  v = 34'sd255;
      TYPE_INT16:  v = 34'sd32767;
      TYPE_UINT16: v = 34'sd65535;
      TYPE_INT32:  v = 34'sd2147483647;
      default:     v = 34'sd4294967295;
    endcase
    return v;
  endfunction

endpackage

[hdl/fqnt_zconv.sv]
// Zero point to single precision conversion, two registered steps.
// Depends on fqnt_pkg; follows the configuration registers continuously.
module fqnt_zconv import fqnt_pkg::*; (
  input  logic        clk,
  input  logic [32:0] zero_ofs,
  input  logic [2:0]  out_type,
  output fq_num_t     zf
);

  logic signed [33:0] z;
  logic [31:0]        mag;
  logic [5:0]         lz;

  logic        z1_sign;
  logic [31:0] z1_mag;
  logic [5:0]  z1_lz;

  logic [31:0] n;
  logic        up;
  logic [24:0] m25;
  logic [7:0]  e;

  always_comb begin
    case (out_type)
      TYPE_INT8:   z = 34'(signed'(zero_ofs[7:0]));
      TYPE_UINT8:  z = {26'b0, zero_ofs[7:0]};
      TYPE_INT16:  z = 34'(signed'(zero_ofs[15:0]));
      TYPE_UINT16: z = {18'b0, zero_ofs[15:0]};
      TYPE_INT32:  z = 34'(signed'(zero_ofs[31:0]));
      default:     z = {2'b0, zero_ofs[31:0]};
    endcase
    mag = z[33] ? 32'(-z) : z[31:0];
    lz  = lzc32(mag);
  end

  always_ff @(posedge clk) begin
    z1_sign <= z[33];
    z1_mag  <= mag;
    z1_lz   <= lz;
  end

  always_comb begin
    n   = z1_mag << z1_lz;
    up  = n[7] & ((|n[6:0]) | n[8]);
    m25 = {1'b0, n[31:8]} + {24'b0, up};
    e   = 8'd158 - {2'b0, z1_lz};
  end

  always_ff @(posedge clk) begin
    zf.sign <= z1_sign;
    if (z1_mag == 32'd0) begin
      zf.expo <= 8'd1;
      zf.mant <= 24'd0;
    end else if (m25[24]) begin
      zf.expo <= e + 8'd1;
      zf.mant <= m25[24:1];
    end else begin
      zf.expo <= e;
      zf.mant <= m25[23:0];
    end
  end

endmodule

[hdl/fqnt_div.sv]
// Pipelined single precision divider with round to nearest-even.
// Depends on fqnt_pkg; unpack, normalise, radix-2 steps, denormalise, round.
module fqnt_div import fqnt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] value_bits,
  input  logic [31:0] scale_bits,
  input  fq_tag_t     in_tag,
  output logic        out_valid,
  output logic [31:0] quot,
  output fq_tag_t     out_tag
);

  typedef struct packed {
    fq_tag_t     tag;
    logic        sign;
    logic        nan;
    logic        inf;
    logic        zero;
    logic [10:0] expo;
    logic [23:0] dsr;
    logic [24:0] rem;
    logic [25:0] quo;
  } dv_t;

  // unpack
  logic [7:0] af, bf;
  logic       a_nan, a_inf, a_zero, b_nan, b_inf, b_zero, r_nan;

  logic        s1_valid;
  fq_tag_t     s1_tag;
  logic        s1_sign, s1_nan, s1_inf, s1_zero;
  logic [7:0]  s1_ea, s1_eb;
  logic [23:0] s1_ma, s1_mb;
  logic [4:0]  s1_lza, s1_lzb;

  always_comb begin
    af     = value_bits[30:23];
    bf     = scale_bits[30:23];
    a_nan  = (af == 8'hFF) && (value_bits[22:0] != 23'd0);
    a_inf  = (af == 8'hFF) && (value_bits[22:0] == 23'd0);
    a_zero = (af == 8'h00) && (value_bits[22:0] == 23'd0);
    b_nan  = (bf == 8'hFF) && (scale_bits[22:0] != 23'd0);
    b_inf  = (bf == 8'hFF) && (scale_bits[22:0] == 23'd0);
    b_zero = (bf == 8'h00) && (scale_bits[22:0] == 23'd0);
    r_nan  = a_nan | b_nan | (a_inf & b_inf) | (a_zero & b_zero);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (en) begin
      s1_valid <= in_valid;
    end
    if (en) begin
      s1_tag  <= in_tag;
      s1_sign <= value_bits[31] ^ scale_bits[31];
      s1_nan  <= r_nan;
      s1_inf  <= (a_inf | b_zero) & ~r_nan;
      s1_zero <= (a_zero | b_inf) & ~r_nan;
      s1_ea   <= (af == 8'h00) ? 8'd1 : af;
      s1_eb   <= (bf == 8'h00) ? 8'd1 : bf;
      s1_ma   <= {af != 8'h00, value_bits[22:0]};
      s1_mb   <= {bf != 8'h00, scale_bits[22:0]};
      s1_lza  <= 5'(lzc32({af != 8'h00, value_bits[22:0], 8'h00}));
      s1_lzb  <= 5'(lzc32({bf != 8'h00, scale_bits[22:0], 8'h00}));
    end
  end

  // normalise
  logic [23:0] ma_n, mb_n;
  logic        lt;
  logic [10:0] e2;

  always_comb begin
    ma_n = s1_ma << s1_lza;
    mb_n = s1_mb << s1_lzb;
    lt   = ma_n < mb_n;
    e2   = {3'b0, s1_ea} - {6'b0, s1_lza} - {3'b0, s1_eb} + {6'b0, s1_lzb}
         + 11'd127 - {10'b0, lt};
  end

  logic        dv_valid [0:DIV_STAGES];
  dv_t         st       [0:DIV_STAGES];
  dv_t         nx       [0:DIV_STAGES-1];
  logic [24:0] sr;
  logic [25:0] sq;
  logic        sb;

  always_comb begin
    sr = 25'd0;
    sq = 26'd0;
    sb = 1'b0;
    for (int g = 0; g < DIV_STAGES; g++) begin
      sr = st[g].rem;
      sq = st[g].quo;
      for (int k = 0; k < DIV_STEPS_PER_STAGE; k++) begin
        sb = sr >= {1'b0, st[g].dsr};
        if (sb) begin
          sr = sr - {1'b0, st[g].dsr};
        end
        sr = {sr[23:0], 1'b0};
        sq = {sq[24:0], sb};
      end
      nx[g]     = st[g];
      nx[g].rem = sr;
      nx[g].quo = sq;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      for (int g = 0; g <= DIV_STAGES; g++) begin
        dv_valid[g] <= 1'b0;
      end
    end else if (en) begin
      dv_valid[0] <= s1_valid;
      for (int g = 0; g < DIV_STAGES; g++) begin
        dv_valid[g+1] <= dv_valid[g];
      end
    end
    if (en) begin
      st[0].tag  <= s1_tag;
      st[0].sign <= s1_sign;
      st[0].nan  <= s1_nan;
      st[0].inf  <= s1_inf;
      st[0].zero <= s1_zero;
      st[0].expo <= e2;
      st[0].dsr  <= mb_n;
      st[0].rem  <= lt ? {ma_n, 1'b0} : {1'b0, ma_n};
      st[0].quo  <= 26'd0;
      for (int g = 0; g < DIV_STAGES; g++) begin
        st[g+1] <= nx[g];
      end
    end
  end

  // denormalise
  logic [26:0]        x, xs, lost_mask;
  logic signed [10:0] es, shw;
  logic [4:0]         shc;

  logic        r1_valid;
  fq_tag_t     r1_tag;
  logic        r1_sign, r1_nan, r1_inf, r1_zero, r1_ovf;
  logic [7:0]  r1_e;
  logic [26:0] r1_x;

  always_comb begin
    x         = {st[DIV_STAGES].quo, |st[DIV_STAGES].rem};
    es        = $signed(st[DIV_STAGES].expo);
    shw       = 11'sd1 - es;
    shc       = (shw > 11'sd27) ? 5'd27 : shw[4:0];
    lost_mask = ~(27'h7FF_FFFF << shc);
    if (es >= 11'sd1) begin
      xs = x;
    end else begin
      xs = (x >> shc) | {26'b0, |(x & lost_mask)};
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      r1_valid <= 1'b0;
    end else if (en) begin
      r1_valid <= dv_valid[DIV_STAGES];
    end
    if (en) begin
      r1_tag  <= st[DIV_STAGES].tag;
      r1_sign <= st[DIV_STAGES].sign;
      r1_nan  <= st[DIV_STAGES].nan;
      r1_inf  <= st[DIV_STAGES].inf;
      r1_zero <= st[DIV_STAGES].zero;
      r1_ovf  <= es >= 11'sd255;
      r1_e    <= (es >= 11'sd1) ? es[7:0] : 8'd0;
      r1_x    <= xs;
    end
  end

  // round and pack
  logic        up;
  logic [30:0] pk;

  always_comb begin
    up = r1_x[2] & (r1_x[1] | r1_x[0] | r1_x[3]);
    pk = {r1_e, r1_x[25:3]} + {30'b0, up};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= r1_valid;
    end
    if (en) begin
      out_tag <= r1_tag;
      if (r1_nan) begin
        quot <= 32'h7FC0_0000;
      end else if (r1_inf || r1_ovf) begin
        quot <= {r1_sign, 8'hFF, 23'd0};
      end else if (r1_zero) begin
        quot <= {r1_sign, 31'd0};
      end else begin
        quot <= {r1_sign, pk};
      end
    end
  end

endmodule

[hdl/fqnt_add.sv]
// Pipelined single precision adder, round to nearest-even, unpacked result.
// Depends on fqnt_pkg; align, add, normalise, round in four stages.
module fqnt_add import fqnt_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        en,
  input  logic        in_valid,
  input  logic [31:0] a,
  input  fq_num_t     zf,
  input  fq_tag_t     in_tag,
  output logic        out_valid,
  output fq_sum_t     sum,
  output fq_tag_t     out_tag
);

  // align
  logic [7:0]  af, ea, e_big, e_sml, d;
  logic [23:0] ma, m_big, m_sml;
  logic        a_big;
  logic [4:0]  dc;
  logic [26:0] xm, al, lost_mask;

  always_comb begin
    af        = a[30:23];
    ea        = (af == 8'h00) ? 8'd1 : af;
    ma        = {af != 8'h00, a[22:0]};
    a_big     = {ea, ma} >= {zf.expo, zf.mant};
    e_big     = a_big ? ea : zf.expo;
    e_sml     = a_big ? zf.expo : ea;
    m_big     = a_big ? ma : zf.mant;
    m_sml     = a_big ? zf.mant : ma;
    d         = e_big - e_sml;
    dc        = (d > 8'd27) ? 5'd27 : d[4:0];
    xm        = {m_sml, 3'b0};
    lost_mask = ~(27'h7FF_FFFF << dc);
    al        = (xm >> dc) | {26'b0, |(xm & lost_mask)};
  end

  logic        a1_valid;
  fq_tag_t     a1_tag;
  logic        a1_sign, a1_sub, a1_nan, a1_inf;
  logic [7:0]  a1_e;
  logic [26:0] a1_mb, a1_ms;

  always_ff @(posedge clk) begin
    if (rst) begin
      a1_valid <= 1'b0;
    end else if (en) begin
      a1_valid <= in_valid;
    end
    if (en) begin
      a1_tag  <= in_tag;
      a1_sign <= a_big ? a[31] : zf.sign;
      a1_sub  <= a[31] ^ zf.sign;
      a1_nan  <= (af == 8'hFF) && (a[22:0] != 23'd0);
      a1_inf  <= (af == 8'hFF) && (a[22:0] == 23'd0);
      a1_e    <= e_big;
      a1_mb   <= {m_big, 3'b0};
      a1_ms   <= al;
    end
  end

  // add
  logic        a2_valid;
  fq_tag_t     a2_tag;
  logic        a2_sign, a2_nan, a2_inf;
  logic [7:0]  a2_e;
  logic [27:0] a2_s;

  always_ff @(posedge clk) begin
    if (rst) begin
      a2_valid <= 1'b0;
    end else if (en) begin
      a2_valid <= a1_valid;
    end
    if (en) begin
      a2_tag  <= a1_tag;
      a2_sign <= a1_sign;
      a2_nan  <= a1_nan;
      a2_inf  <= a1_inf;
      a2_e    <= a1_e;
      a2_s    <= a1_sub ? ({1'b0, a1_mb} - {1'b0, a1_ms}) : ({1'b0, a1_mb} + {1'b0, a1_ms});
    end
  end

  // normalise
  logic [5:0]  lz;
  logic [7:0]  lim, sh;
  logic [26:0] n;
  logic [8:0]  en9;

  always_comb begin
    lz  = lzc32({a2_s[26:0], 5'b0});
    lim = a2_e - 8'd1;
    sh  = ({2'b0, lz} > lim) ? lim : {2'b0, lz};
    if (a2_s[27]) begin
      n   = {a2_s[27:2], a2_s[1] | a2_s[0]};
      en9 = {1'b0, a2_e} + 9'd1;
    end else begin
      n   = a2_s[26:0] << sh;
      en9 = {1'b0, a2_e} - {1'b0, sh};
    end
  end

  logic        a3_valid;
  fq_tag_t     a3_tag;
  logic        a3_sign, a3_nan, a3_inf;
  logic [8:0]  a3_e;
  logic [26:0] a3_n;

  always_ff @(posedge clk) begin
    if (rst) begin
      a3_valid <= 1'b0;
    end else if (en) begin
      a3_valid <= a2_valid;
    end
    if (en) begin
      a3_tag  <= a2_tag;
      a3_sign <= a2_sign;
      a3_nan  <= a2_nan;
      a3_inf  <= a2_inf;
      a3_e    <= en9;
      a3_n    <= n;
    end
  end

  // round
  logic        up;
  logic [24:0] m25;

  always_comb begin
    up  = a3_n[2] & (a3_n[1] | a3_n[0] | a3_n[3]);
    m25 = {1'b0, a3_n[26:3]} + {24'b0, up};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= a3_valid;
    end
    if (en) begin
      out_tag  <= a3_tag;
      sum.sign <= a3_sign;
      sum.nan  <= a3_nan;
      sum.inf  <= a3_inf;
      if (m25[24]) begin
        sum.expo <= a3_e + 9'd1;
        sum.mant <= m25[24:1];
      end else begin
        sum.expo <= a3_e;
        sum.mant <= m25[23:0];
      end
    end
  end

endmodule

[hdl/fqnt_cvt.sv]
// Float to integer conversion, ties away from zero, with saturation to type.
// Depends on fqnt_pkg; holds the output register of the block.
module fqnt_cvt import fqnt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               en,
  input  logic               in_valid,
  input  fq_sum_t            sum,
  input  logic [2:0]         out_type,
  input  fq_tag_t            in_tag,
  output logic               out_valid,
  output logic signed [32:0] quantized,
  output logic               bad_scale,
  output logic               last_out
);

  logic [8:0]  sh;
  logic [63:0] fx;

  always_comb begin
    sh = 9'd158 - sum.expo;
    fx = {sum.mant, 40'b0} >> sh;
  end

  logic        f1_valid;
  fq_tag_t     f1_tag;
  logic        f1_sign, f1_nan, f1_sat;
  logic [32:0] f1_f;

  always_ff @(posedge clk) begin
    if (rst) begin
      f1_valid <= 1'b0;
    end else if (en) begin
      f1_valid <= in_valid;
    end
    if (en) begin
      f1_tag  <= in_tag;
      f1_sign <= sum.sign;
      f1_nan  <= sum.nan;
      f1_sat  <= sum.inf | (sum.expo >= 9'd159);
      f1_f    <= fx[63:31];
    end
  end

  logic [32:0]        mag;
  logic signed [33:0] v, lo, hi, res;

  always_comb begin
    mag = {1'b0, f1_f[32:1]} + {32'b0, f1_f[0]};
    v   = f1_sign ? -$signed({1'b0, mag}) : $signed({1'b0, mag});
    lo  = type_lo(out_type);
    hi  = type_hi(out_type);
    if (f1_tag.bad) begin
      res = 34'sd0;
    end else if (f1_nan) begin
      res = hi;
    end else if (f1_sat) begin
      res = f1_sign ? lo : hi;
    end else if (v < lo) begin
      res = lo;
    end else if (v > hi) begin
      res = hi;
    end else begin
      res = v;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (en) begin
      out_valid <= f1_valid;
    end
    if (en) begin
      quantized <= res[32:0];
      bad_scale <= f1_tag.bad;
      last_out  <= f1_tag.last;
    end
  end

endmodule

[hdl/float32_affine_quantizer_unit.sv]
// Top level of the float32 affine quantiser: configuration registers and
// the divider, adder and converter pipelines. Depends on fqnt_pkg and all fqnt_ modules.
//
//   channel   signals                                      direction
//   request   in_valid, in_ready, value_bits, last         in
//   result    out_valid, out_ready, quantized, bad_scale,  out
//             last_out
//   config    cfg_wen, cfg_index, cfg_data                 in
//
// One request enters per cycle unless a held result stalls the pipeline.
// The divider performs its 26 quotient steps two per stage.
// Reset restores scale 1.0, zero point 0 and int8, and empties the pipeline.
// A held result stalls every stage together; in_ready falls only then.
module float32_affine_quantizer_unit import fqnt_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        value_bits,
  input  logic               last,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [32:0] quantized,
  output logic               bad_scale,
  output logic               last_out,
  input  logic               cfg_wen,
  input  logic [1:0]         cfg_index,
  input  logic [32:0]        cfg_data
);

  logic [31:0] scale_bits;
  logic [32:0] zero_ofs;
  logic [2:0]  out_type;
  logic        en;

  always_ff @(posedge clk) begin
    if (rst) begin
      scale_bits <= SCALE_RESET;
      zero_ofs   <= 33'd0;
      out_type   <= TYPE_INT8;
    end else if (cfg_wen) begin
      case (cfg_index)
        REG_SCALE: scale_bits <= cfg_data[31:0];
        REG_ZERO:  zero_ofs   <= cfg_data;
        REG_TYPE:  out_type   <= cfg_data[2:0];
        default:   ;
      endcase
    end
  end

  assign en       = ~out_valid | out_ready;
  assign in_ready = en;

  logic [2:0] typ;
  assign typ = (out_type > TYPE_UINT32) ? TYPE_UINT32 : out_type;

  fq_num_t zf;

  fqnt_zconv u_zconv (
    .clk      (clk),
    .zero_ofs (zero_ofs),
    .out_type (typ),
    .zf       (zf)
  );

  fq_tag_t     tag_in, tag_div, tag_add;
  logic        div_valid, add_valid;
  logic [31:0] quot;
  fq_sum_t     sum;

  assign tag_in.last = last;
  assign tag_in.bad  = scale_bits[30:0] == 31'd0;

  fqnt_div u_div (
    .clk        (clk),
    .rst        (rst),
    .en         (en),
    .in_valid   (in_valid),
    .value_bits (value_bits),
    .scale_bits (scale_bits),
    .in_tag     (tag_in),
    .out_valid  (div_valid),
    .quot       (quot),
    .out_tag    (tag_div)
  );

  fqnt_add u_add (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (div_valid),
    .a         (quot),
    .zf        (zf),
    .in_tag    (tag_div),
    .out_valid (add_valid),
    .sum       (sum),
    .out_tag   (tag_add)
  );

  fqnt_cvt u_cvt (
    .clk       (clk),
    .rst       (rst),
    .en        (en),
    .in_valid  (add_valid),
    .sum       (sum),
    .out_type  (typ),
    .in_tag    (tag_add),
    .out_valid (out_valid),
    .quantized (quantized),
    .bad_scale (bad_scale),
    .last_out  (last_out)
  );

endmodule

[verif/float32_affine_quantizer_unit_tb.sv]
// Testbench for float32_affine_quantizer_unit: directed and random requests
// checked against a behavioural predictor built on double-precision arithmetic.
// Depends on fqnt_pkg and the RTL of the block.
module float32_affine_quantizer_unit_tb import fqnt_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int LATENCY     = 30;
  localparam int CYCLE_LIMIT = 600000;

  typedef struct {
    logic [32:0] quantized;
    logic        bad_scale;
    logic        last_out;
  } quant_result_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [31:0] value_bits = '0;
  logic        last = 1'b0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic signed [32:0] quantized;
  logic        bad_scale;
  logic        last_out;
  logic        cfg_wen = 1'b0;
  logic [1:0]  cfg_index = REG_SCALE;
  logic [32:0] cfg_data = '0;

  logic [31:0] cur_scale = SCALE_RESET;
  logic [32:0] cur_zero  = '0;
  logic [2:0]  cur_type  = TYPE_INT8;

  quant_result_t pending_q[$];
  int  errors = 0;
  int  cycles = 0;
  bit  hold_req = 1'b0;
  bit  long_gaps = 1'b1;

  float32_affine_quantizer_unit dut (.*);

  always #5 clk = ~clk;

  function automatic real bits_to_real(input logic [31:0] b);
    real r;
    if (b[30:23] == 8'hFF)
      return $bitstoreal(b[22:0] != 0 ? 64'h7FF8_0000_0000_0000
                                     : {b[31], 63'h7FF0_0000_0000_0000});
    if (b[30:23] == 8'h00) begin
      r = real'(b[22:0]) / (2.0 ** 149);
      return b[31] ? -r : r;
    end
    return $bitstoreal({b[31], 11'(int'(b[30:23]) - 127 + 1023), b[22:0], 29'b0});
  endfunction

  // round a double to binary32, nearest-even, subnormals kept
  function automatic logic [31:0] real_to_bits(input real x);
    logic [63:0] d, sig, kept, rem, half;
    int          fe, s;
    d = $realtobits(x);
    if (d[62:52] == 11'h7FF)
      return d[51:0] != 0 ? 32'h7FC0_0000 : {d[63], 31'h7F80_0000};
    if (d[62:52] == 11'h000)
      return {d[63], 31'b0};
    fe  = int'(d[62:52]) - 1023 + 127;
    sig = {11'b0, 1'b1, d[51:0]};
    s   = 29;
    if (fe < 1) begin
      s  = 30 - fe;
      fe = 0;
    end
    if (s > 60)
      return {d[63], 31'b0};
    kept = sig >> s;
    rem  = sig & ((64'd1 << s) - 1);
    half = 64'd1 << (s - 1);
    if (rem > half || (rem == half && kept[0]))
      kept++;
    if (fe == 0)
      return {d[63], kept[30:0]};
    if (kept[24]) begin
      kept = kept >> 1;
      fe++;
    end
    if (fe >= 255)
      return {d[63], 31'h7F80_0000};
    return {d[63], fe[7:0], kept[22:0]};
  endfunction

  function automatic quant_result_t quantise(input logic [31:0] v, input logic l);
    quant_result_t res;
    logic [2:0]    t;
    longint        zp, lo, hi, r;
    logic [31:0]   q, zf, sum;
    real           x;
    t = cur_type > TYPE_UINT32 ? TYPE_UINT32 : cur_type;
    res.last_out = l;
    res.bad_scale = 1'b0;
    if (cur_scale[30:0] == 0) begin
      res.quantized = '0;
      res.bad_scale = 1'b1;
      return res;
    end
    case (t)
      TYPE_INT8:   begin zp = longint'($signed(cur_zero[7:0]));  lo = -128;  hi = 127;   end
      TYPE_UINT8:  begin zp = longint'(cur_zero[7:0]);           lo = 0;     hi = 255;   end
      TYPE_INT16:  begin zp = longint'($signed(cur_zero[15:0])); lo = -32768; hi = 32767; end
      TYPE_UINT16: begin zp = longint'(cur_zero[15:0]);          lo = 0;     hi = 65535; end
      TYPE_INT32:  begin
        zp = longint'($signed(cur_zero[31:0])); lo = -64'sd2147483648; hi = 64'sd2147483647;
      end
      default:     begin zp = longint'(cur_zero[31:0]); lo = 0; hi = 64'sd4294967295; end
    endcase
    q   = real_to_bits(bits_to_real(v) / bits_to_real(cur_scale));
    zf  = real_to_bits(real'(zp));
    sum = real_to_bits(bits_to_real(q) + bits_to_real(zf));
    x   = bits_to_real(sum);
    if (sum[30:23] == 8'hFF && sum[22:0] != 0) r = hi;
    else if (x >= 4294967296.0) r = hi;
    else if (x <= -4294967296.0) r = lo;
    else begin
      r = longint'(x);
      if (r < lo) r = lo;
      if (r > hi) r = hi;
    end
    res.quantized = r[32:0];
    return res;
  endfunction

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("float32_affine_quantizer_unit: mismatch");
      $finish;
    end
  end

  // result side: random stalls, plus one long hold-off on request
  initial begin : result_stall
    int n;
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        repeat (300) @(posedge clk);
        hold_req = 1'b0;
      end
      n = $urandom_range(0, 99);
      if (n < 60 || !long_gaps) out_ready <= 1'b1;
      else if (n < 95) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(0, 3)) @(posedge clk);
      end else begin
        out_ready <= 1'b0;
        repeat ($urandom_range(10, 40)) @(posedge clk);
      end
    end
  end

  always @(posedge clk) begin
    quant_result_t e;
    if (!rst && out_valid && out_ready) begin
      if (pending_q.size() == 0) begin
        $error("quantized: unexpected result %h", quantized);
        errors++;
      end else begin
        e = pending_q.pop_front();
        if (quantized !== e.quantized) begin
          $error("quantized: expected %h actual %h", e.quantized, quantized);
          errors++;
        end
        if (bad_scale !== e.bad_scale) begin
          $error("bad_scale: expected %b actual %b", e.bad_scale, bad_scale);
          errors++;
        end
        if (last_out !== e.last_out) begin
          $error("last_out: expected %b actual %b", e.last_out, last_out);
          errors++;
        end
      end
    end
  end

  task automatic send_request(input logic [31:0] v, input logic l);
    int n, gap;
    n = $urandom_range(0, 99);
    gap = !long_gaps ? 0 : n < 55 ? 0 : n < 95 ? $urandom_range(1, 3) : $urandom_range(8, 40);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid   <= 1'b1;
    value_bits <= v;
    last       <= l;
    do @(posedge clk); while (!in_ready);
    pending_q.push_back(quantise(v, l));
  endtask

  task automatic drain;
    in_valid <= 1'b0;
    while (pending_q.size() != 0) @(posedge clk);
    repeat (LATENCY) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [32:0] data);
    drain();
    cfg_wen   <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    cfg_wen <= 1'b0;
    case (idx)
      REG_SCALE: cur_scale = data[31:0];
      REG_ZERO:  cur_zero  = data;
      default:   cur_type  = data[2:0];
    endcase
  endtask

  function automatic logic [31:0] rand_float;
    int n;
    n = $urandom_range(0, 99);
    if (n < 15) return $urandom;
    if (n < 25) begin
      case ($urandom_range(0, 5))
        0: return 32'h0000_0000;
        1: return 32'h8000_0000;
        2: return 32'h7F80_0000;
        3: return 32'hFF80_0000;
        4: return {$urandom_range(0, 1) == 1, 8'hFF, 23'($urandom) | 23'h1};
        default: return {$urandom_range(0, 1) == 1, 8'h00, 23'($urandom)};
      endcase
    end
    if (n < 40) return {$urandom_range(0, 1) == 1, 8'($urandom_range(126, 128)), 23'($urandom)};
    return {$urandom_range(0, 1) == 1, 8'($urandom_range(100, 160)), 23'($urandom)};
  endfunction

  task automatic test_defaults;
    send_request(32'h3F80_0000, 1'b0);
    send_request(32'h3F00_0000, 1'b1);
    send_request(32'hBF00_0000, 1'b0);
    send_request(32'h4020_0000, 1'b0);
    send_request(32'h42FF_0000, 1'b0);
    send_request(32'hC301_0000, 1'b1);
    send_request(32'h7F80_0000, 1'b0);
    send_request(32'hFF80_0000, 1'b0);
    send_request(32'h7FC0_0000, 1'b0);
    send_request(32'hFFFF_FFFF, 1'b0);
    send_request(32'h0000_0001, 1'b0);
    send_request(32'h807F_FFFF, 1'b0);
    send_request(32'h7F7F_FFFF, 1'b1);
    send_request(32'h0000_0000, 1'b0);
    send_request(32'h8000_0000, 1'b0);
  endtask

  task automatic test_edge_config;
    write_reg(REG_SCALE, 33'h0_0000_0000);
    send_request(32'h3F80_0000, 1'b1);
    write_reg(REG_SCALE, 33'h0_8000_0000);
    send_request(32'h4000_0000, 1'b0);
    write_reg(REG_SCALE, 33'h0_7FC0_0000);
    send_request(32'h3F80_0000, 1'b0);
    write_reg(REG_SCALE, 33'h0_0000_0001);
    send_request(32'h0000_0003, 1'b0);
    write_reg(REG_ZERO, 33'h1_FFFF_FFFF);
    for (int t = 0; t < 8; t++) begin
      write_reg(REG_TYPE, 33'(t));
      send_request(32'hC000_0000, 1'b0);
    end
    write_reg(REG_SCALE, 33'h0_3F80_0000);
    write_reg(REG_ZERO, 33'h0_8000_0000);
    write_reg(REG_TYPE, 33'(TYPE_INT32));
    send_request(32'h4F00_0000, 1'b0);
    send_request(32'hCF00_0000, 1'b1);
  endtask

  task automatic test_random(input int phases, input int per_phase);
    for (int p = 0; p < phases; p++) begin
      case ($urandom_range(0, 3))
        0: write_reg(REG_SCALE, 33'($urandom));
        1: write_reg(REG_SCALE, {1'b0, 1'($urandom), 8'($urandom_range(110, 140)), 23'($urandom)});
        default: write_reg(REG_SCALE, {1'b0, 32'h3F80_0000});
      endcase
      case ($urandom_range(0, 3))
        0: write_reg(REG_ZERO, {1'($urandom), 32'($urandom)});
        1: write_reg(REG_ZERO, 33'($urandom_range(0, 300)));
        2: write_reg(REG_ZERO, -33'($urandom_range(0, 300)));
        default: write_reg(REG_ZERO, 33'h0);
      endcase
      write_reg(REG_TYPE, 33'($urandom_range(0, 7)));
      long_gaps = (p % 4) != 3;
      for (int i = 0; i < per_phase; i++)
        send_request(rand_float(), 1'($urandom));
    end
    long_gaps = 1'b1;
  endtask

  task automatic test_backpressure;
    write_reg(REG_TYPE, 33'(TYPE_INT16));
    long_gaps = 1'b0;
    hold_req  = 1'b1;
    for (int i = 0; i < 80; i++)
      send_request(rand_float(), 1'($urandom));
    long_gaps = 1'b1;
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_defaults();
    test_edge_config();
    test_backpressure();
    test_random(10, 85);
    drain();
    if (errors == 0) $display("float32_affine_quantizer_unit: match");
    else $display("float32_affine_quantizer_unit: mismatch");
    $finish;
  end

endmodule

[sim.f]
hdl/fqnt_pkg.sv
hdl/fqnt_zconv.sv
hdl/fqnt_div.sv
hdl/fqnt_add.sv
hdl/fqnt_cvt.sv
hdl/float32_affine_quantizer_unit.sv
verif/float32_affine_quantizer_unit_tb.sv
